// ----- design/blsf_pkg.sv -----
// ----------------------------------------------------------------------------
// Low-shelf biquad package
// Shared constants, register indexes and the control and status types that
// pass between the top level and the bit-serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
package blsf_pkg;

  // Fixed widths of the datapath.
  localparam int INTERNAL_BITS = 40;
  localparam int COEF_BITS     = 32;
  // Partial-sum width: a coefficient plus room for three terms and the carry.
  localparam int ACC_W         = COEF_BITS + 3;

  // Defaults for the top-level parameters.
  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 24;

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FF0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FF1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FF2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FB1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FB2 = 3'd4;

  // Control into the multiply-accumulate unit.
  typedef struct packed {
    logic start;   // load operands and begin a pass
    logic narrow;  // saturate to the sample range instead of the internal range
  } blsf_ctl_t;

  // Status out of the multiply-accumulate unit.
  typedef struct packed {
    logic done;    // result is valid this cycle
    logic sat;     // result was saturated
  } blsf_sts_t;

endpackage

// ----- design/low_shelf_biquad_filter_top.sv -----
// ----------------------------------------------------------------------------
// Low-shelf biquad filter
// Direct form II second-order section with saturation of the internal value
// and of the output, built around a bit-serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one signed sample per item on s_axis_tdata.
//   Output stream: the filtered sample on m_axis_tdata and the clip flag on
//   m_axis_tuser, one result item per input item.
//   The user must write coefficients via cfg_we_i / cfg_idx_i / cfg_data_i only
//   while the filter is idle, unchecked by the block; higher indexes are ignored.
// Operation:
//   Each item makes two passes through the serial unit, one data bit per
//   cycle over the 40-bit delay width: the feedback sum, then the feedforward
//   sum. A finished item moves into the output register and is offered there;
//   the input is ready again once the item has moved, so a new item is not
//   taken before the last one is through the serial unit.
//   The serial unit is shared by both passes.
// Reset and stalls:
//   Reset clears both delays and sets the coefficients to unity gain. A
//   finished item waits in the output register while the next item is taken
//   and filtered; a new result waits until the output register is free.
// ----------------------------------------------------------------------------
module low_shelf_biquad_filter_top #(
  parameter int SAMPLE_WIDTH   = blsf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = blsf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port.
  input  logic                                   cfg_we_i,
  input  logic [blsf_pkg::REG_IDX_W-1:0]         cfg_idx_i,
  input  logic [blsf_pkg::COEF_BITS-1:0]         cfg_data_i,
  // Input stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // sample_in, zero pad
  // Output stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,  // sample_out, zero pad
  output logic                                   m_axis_tuser   // clipped
);
  import blsf_pkg::*;

  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam logic [COEF_BITS-1:0] UNITY = COEF_BITS'(1) << COEF_FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FB   = 2'd1;
  localparam logic [1:0] ST_FF   = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  logic [1:0]                      state_q;
  logic [COEF_BITS-1:0]            ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;
  logic [INTERNAL_BITS-1:0]        d1_q, d2_q, w_q;
  logic [SAMPLE_WIDTH-1:0]         y_q, out_q;
  logic                            sat_q, clip_q, out_clip_q, out_valid_q;
  logic                            s_acc;
  logic [INTERNAL_BITS-1:0]        x_ext;
  blsf_ctl_t                       ctl;
  blsf_sts_t                       sts;
  logic [2:0][COEF_BITS-1:0]       coef;
  logic [2:0][INTERNAL_BITS-1:0]   data;
  logic [INTERNAL_BITS-1:0]        res;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign x_ext = {{(INTERNAL_BITS-SAMPLE_WIDTH){s_axis_tdata[SAMPLE_WIDTH-1]}},
                  s_axis_tdata[SAMPLE_WIDTH-1:0]};

  // Operand selection: the feedback pass starts on accept, the feedforward
  // pass starts as soon as the internal value is known.
  always_comb begin
    ctl.start  = s_acc | ((state_q == ST_FB) & sts.done);
    ctl.narrow = (state_q == ST_FB);
    if (state_q == ST_IDLE) begin
      coef = {fb2_q, fb1_q, UNITY};
      data = {d2_q, d1_q, x_ext};
    end else begin
      coef = {ff2_q, ff1_q, ff0_q};
      data = {d2_q, d1_q, res};
    end
  end

  blsf_mac #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .coef_i (coef),
    .data_i (data),
    .sts_o  (sts),
    .res_o  (res)
  );

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff0_q <= UNITY;
      ff1_q <= '0;
      ff2_q <= '0;
      fb1_q <= '0;
      fb2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FF0: ff0_q <= cfg_data_i;
        REG_FF1: ff1_q <= cfg_data_i;
        REG_FF2: ff2_q <= cfg_data_i;
        REG_FB1: fb1_q <= cfg_data_i;
        REG_FB2: fb2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer, delay line and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      d1_q        <= '0;
      d2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A finished item enters the output register when it is free or
      // being emptied in this cycle.
      if (state_q == ST_WAIT && (!out_valid_q | m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q & m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            state_q <= ST_FB;
          end
        end
        ST_FB: begin
          if (sts.done) begin
            state_q <= ST_FF;
          end
        end
        ST_FF: begin
          if (sts.done) begin
            d2_q    <= d1_q;
            d1_q    <= w_q;
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!out_valid_q | m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers of the pass results and the output item.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FB && sts.done) begin
      w_q   <= res;
      sat_q <= sts.sat;
    end
    if (state_q == ST_FF && sts.done) begin
      y_q    <= res[SAMPLE_WIDTH-1:0];
      clip_q <= sat_q | sts.sat;
    end
    if (state_q == ST_WAIT && (!out_valid_q | m_axis_tready)) begin
      out_q      <= y_q;
      out_clip_q <= clip_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_W'(out_q);
  assign m_axis_tuser  = out_clip_q;

endmodule

// ----- design/blsf_mac.sv -----
// ----------------------------------------------------------------------------
// Bit-serial sum of three products
// Forms c0*d0 + c1*d1 + c2*d2 one data bit per cycle, LSB first, with the
// coefficients in parallel. Rounds, shifts right by the fraction bits and
// saturates to the internal or to the sample range.
// ----------------------------------------------------------------------------
module blsf_mac #(
  parameter int SAMPLE_WIDTH   = blsf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = blsf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  blsf_pkg::blsf_ctl_t                           ctl_i,
  input  logic [2:0][blsf_pkg::COEF_BITS-1:0]           coef_i,
  input  logic [2:0][blsf_pkg::INTERNAL_BITS-1:0]       data_i,
  output blsf_pkg::blsf_sts_t                           sts_o,
  output logic [blsf_pkg::INTERNAL_BITS-1:0]            res_o
);
  import blsf_pkg::*;

  localparam int CNT_W = $clog2(INTERNAL_BITS);
  localparam int TW    = ACC_W + INTERNAL_BITS;
  localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(INTERNAL_BITS - 1);
  localparam logic [CNT_W-1:0] ROUND_BIT = CNT_W'(COEF_FRAC_BITS - 1);

  // Saturation limits, both held in the internal width.
  localparam logic [INTERNAL_BITS-1:0] W_MAX = {1'b0, {(INTERNAL_BITS-1){1'b1}}};
  localparam logic [INTERNAL_BITS-1:0] S_MAX =
    (INTERNAL_BITS'(1) << (SAMPLE_WIDTH - 1)) - INTERNAL_BITS'(1);

  logic                               busy_q, done_q, narrow_q;
  logic [CNT_W-1:0]                   cnt_q;
  logic [ACC_W-1:0]                   acc_q, acc_d;
  logic [INTERNAL_BITS-1:0]           low_q;
  logic [2:0][COEF_BITS-1:0]          coef_q;
  logic [2:0][INTERNAL_BITS-1:0]      sh_q;
  logic [2:0][ACC_W-1:0]              term;
  logic [ACC_W-1:0]                   sum;
  logic                               last;
  logic [TW-1:0]                      total, rsh;
  logic [TW-INTERNAL_BITS:0]          hi_w;
  logic [TW-SAMPLE_WIDTH:0]           hi_s;
  logic                               neg, fits;

  assign last = (cnt_q == LAST_BIT);

  // One partial product per lane; the top data bit carries negative weight.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term[k] = '0;
      if (sh_q[k][0]) begin
        term[k] = {{(ACC_W-COEF_BITS){coef_q[k][COEF_BITS-1]}}, coef_q[k]};
        if (last) begin
          term[k] = -term[k];
        end
      end
    end
    // The rounding half enters as a carry at its own bit weight.
    sum   = acc_q + term[0] + term[1] + term[2]
          + {{(ACC_W-1){1'b0}}, (cnt_q == ROUND_BIT)};
    acc_d = {sum[ACC_W-1], sum[ACC_W-1:1]};
  end

  // Control: bit counter and pass state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      narrow_q <= 1'b0;
    end else begin
      done_q <= busy_q & last;
      if (ctl_i.start) begin
        busy_q   <= 1'b1;
        cnt_q    <= '0;
        narrow_q <= ctl_i.narrow;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: operand shift registers and the partial sum.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      coef_q <= coef_i;
      sh_q   <= data_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      for (int k = 0; k < 3; k++) begin
        sh_q[k] <= {1'b0, sh_q[k][INTERNAL_BITS-1:1]};
      end
      acc_q <= acc_d;
      low_q <= {sum[0], low_q[INTERNAL_BITS-1:1]};
    end
  end

  // Drop the fraction bits and saturate the finished sum.
  always_comb begin
    total = {acc_q, low_q};
    rsh   = $signed(total) >>> COEF_FRAC_BITS;
    neg   = rsh[TW-1];
    hi_w  = rsh[TW-1:INTERNAL_BITS-1];
    hi_s  = rsh[TW-1:SAMPLE_WIDTH-1];
    if (narrow_q) begin
      fits = (&hi_s) | ~(|hi_s);
      res_o = fits ? rsh[INTERNAL_BITS-1:0] : (neg ? ~S_MAX : S_MAX);
    end else begin
      fits = (&hi_w) | ~(|hi_w);
      res_o = fits ? rsh[INTERNAL_BITS-1:0] : (neg ? ~W_MAX : W_MAX);
    end
    sts_o.done = done_q;
    sts_o.sat  = ~fits;
  end

endmodule

// ----- design/blsf_checker.sv -----
// ----------------------------------------------------------------------------
// Low-shelf biquad port checker
// Watches the stream ports of the filter over time and is bound to the top.
// ----------------------------------------------------------------------------
module blsf_checker #(
  parameter int SAMPLE_WIDTH = blsf_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
  input logic                               m_axis_tuser
);

  // A stalled output item stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  // A stalled output item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  // The filter is busy right after it takes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

  // It stays busy during the serial passes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##3 !s_axis_tready)
    else $error("input ready during the serial passes");

endmodule

bind low_shelf_biquad_filter_top blsf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_blsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
